@@ design/hrp_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser package
// Types, codes and byte classification helpers shared by the parser and its
// checker.
// ----------------------------------------------------------------------------
package hrp_pkg;

  // Parser states, one per position in the request grammar.
  typedef enum logic [4:0] {
    S_METHOD_START = 5'd0,
    S_METHOD       = 5'd1,
    S_URI_START    = 5'd2,
    S_URI          = 5'd3,
    S_VER_H        = 5'd4,
    S_VER_T1       = 5'd5,
    S_VER_T2       = 5'd6,
    S_VER_P        = 5'd7,
    S_VER_SLASH    = 5'd8,
    S_MAJOR_START  = 5'd9,
    S_MAJOR        = 5'd10,
    S_MINOR_START  = 5'd11,
    S_MINOR        = 5'd12,
    S_LF_REQLINE   = 5'd13,
    S_LINE_START   = 5'd14,
    S_LWS          = 5'd15,
    S_NAME         = 5'd16,
    S_SPACE_VALUE  = 5'd17,
    S_VALUE        = 5'd18,
    S_LF_HEADER    = 5'd19,
    S_LF_FINAL     = 5'd20
  } parser_state_t;

  // Status codes.
  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Byte role codes.
  localparam logic [2:0] ROLE_DELIM    = 3'd0;
  localparam logic [2:0] ROLE_METHOD   = 3'd1;
  localparam logic [2:0] ROLE_URI      = 3'd2;
  localparam logic [2:0] ROLE_NEW_NAME = 3'd3;
  localparam logic [2:0] ROLE_NAME     = 3'd4;
  localparam logic [2:0] ROLE_VALUE    = 3'd5;

  // Character constants.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CTL_MAX  = 8'd31;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [19:0] VER_MAX = 20'd65535;

  // One input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  byte_role;
    logic [7:0]  echo_byte;
    logic [15:0] version_major;
    logic [15:0] version_minor;
  } out_item_t;

  // Control bytes are 0 to 31 and DEL.
  function automatic logic is_ctl(input logic [7:0] b);
    return (b <= CTL_MAX) || (b == CH_DEL);
  endfunction

  // Separator characters of the token grammar.
  function automatic logic is_sep(input logic [7:0] b);
    return b inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A,
                     8'h5C, 8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B,
                     8'h7D, CH_SP, CH_TAB};
  endfunction

  // Token bytes are 7-bit, not control, not separator.
  function automatic logic is_token(input logic [7:0] b);
    return !b[7] && !is_ctl(b) && !is_sep(b);
  endfunction

  function automatic logic is_numeral(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // Append one decimal digit, saturating at 65535.
  function automatic logic [15:0] add_digit(input logic [15:0] v,
                                            input logic [7:0]  b);
    logic [19:0] n;
    n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, b[3:0]};
    return (n > VER_MAX) ? 16'hFFFF : n[15:0];
  endfunction

endpackage

@@ design/http_request_header_parser.sv @@
// A transaction passes from the input register to the result register. Throughput:
// one byte per cycle unless the result side stalls; the parser state is a single
// register loop updated in the same cycle the byte moves into the result register.
// Reset (rst, synchronous): both stages empty, parser at method start, header
// flag and both version numbers cleared.
// ----------------------------------------------------------------------------
// HTTP request header parser
// Byte-at-a-time request line and header state machine that tags every byte
// with its role and reports need-more, complete or malformed.
// ----------------------------------------------------------------------------
module http_request_header_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hrp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output hrp_pkg::out_item_t out_item
);

  // Input register.
  logic              in_full;
  hrp_pkg::in_item_t in_q;

  // Parser state.
  hrp_pkg::parser_state_t state, state_next;
  logic                   seen_header, seen_header_next;
  logic [15:0]            major_value, major_value_next;
  logic [15:0]            minor_value, minor_value_next;

  // Result register.
  hrp_pkg::out_item_t result_next;
  logic               advance;

  // The held byte moves on when the result register is free or being taken.
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_q <= in_item;
    end
  end

  // Next-state and result logic for the held byte.
  always_comb begin
    hrp_pkg::parser_state_t s;
    logic [7:0]             b;
    logic [1:0]             st;
    logic [2:0]             role;
    b    = in_q.data_byte;
    st   = hrp_pkg::ST_MORE;
    role = hrp_pkg::ROLE_DELIM;
    if (in_q.restart) begin
      s                = hrp_pkg::S_METHOD_START;
      seen_header_next = 1'b0;
      major_value_next = 16'd0;
      minor_value_next = 16'd0;
    end else begin
      s                = state;
      seen_header_next = seen_header;
      major_value_next = major_value;
      minor_value_next = minor_value;
    end
    state_next = s;

    case (s)
      hrp_pkg::S_METHOD_START: begin
        if (hrp_pkg::is_token(b)) begin
          state_next = hrp_pkg::S_METHOD;
          role       = hrp_pkg::ROLE_METHOD;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_METHOD: begin
        if (b == hrp_pkg::CH_SP) state_next = hrp_pkg::S_URI_START;
        else if (hrp_pkg::is_token(b)) role = hrp_pkg::ROLE_METHOD;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_URI_START: begin
        if (hrp_pkg::is_ctl(b)) st = hrp_pkg::ST_BAD;
        else begin
          state_next = hrp_pkg::S_URI;
          role       = hrp_pkg::ROLE_URI;
        end
      end
      hrp_pkg::S_URI: begin
        if (b == hrp_pkg::CH_SP) state_next = hrp_pkg::S_VER_H;
        else if (hrp_pkg::is_ctl(b)) st = hrp_pkg::ST_BAD;
        else role = hrp_pkg::ROLE_URI;
      end
      hrp_pkg::S_VER_H: begin
        if (b == hrp_pkg::CH_H) state_next = hrp_pkg::S_VER_T1;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_T1: begin
        if (b == hrp_pkg::CH_T) state_next = hrp_pkg::S_VER_T2;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_T2: begin
        if (b == hrp_pkg::CH_T) state_next = hrp_pkg::S_VER_P;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_P: begin
        if (b == hrp_pkg::CH_P) state_next = hrp_pkg::S_VER_SLASH;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_SLASH: begin
        if (b == hrp_pkg::CH_SLASH) begin
          major_value_next = 16'd0;
          minor_value_next = 16'd0;
          state_next       = hrp_pkg::S_MAJOR_START;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MAJOR_START: begin
        if (hrp_pkg::is_numeral(b)) begin
          major_value_next = hrp_pkg::add_digit(major_value_next, b);
          state_next       = hrp_pkg::S_MAJOR;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MAJOR: begin
        if (b == hrp_pkg::CH_DOT) state_next = hrp_pkg::S_MINOR_START;
        else if (hrp_pkg::is_numeral(b)) begin
          major_value_next = hrp_pkg::add_digit(major_value_next, b);
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MINOR_START: begin
        if (hrp_pkg::is_numeral(b)) begin
          minor_value_next = hrp_pkg::add_digit(minor_value_next, b);
          state_next       = hrp_pkg::S_MINOR;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MINOR: begin
        if (b == hrp_pkg::CH_CR) state_next = hrp_pkg::S_LF_REQLINE;
        else if (hrp_pkg::is_numeral(b)) begin
          minor_value_next = hrp_pkg::add_digit(minor_value_next, b);
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_LF_REQLINE: begin
        if (b == hrp_pkg::CH_LF) state_next = hrp_pkg::S_LINE_START;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_LINE_START: begin
        // A fold line is only legal once some header has begun.
        if (b == hrp_pkg::CH_CR) state_next = hrp_pkg::S_LF_FINAL;
        else if (seen_header_next &&
                 (b == hrp_pkg::CH_SP || b == hrp_pkg::CH_TAB)) begin
          state_next = hrp_pkg::S_LWS;
        end else if (hrp_pkg::is_token(b)) begin
          seen_header_next = 1'b1;
          role             = hrp_pkg::ROLE_NEW_NAME;
          state_next       = hrp_pkg::S_NAME;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_LWS: begin
        if (b == hrp_pkg::CH_CR) state_next = hrp_pkg::S_LF_HEADER;
        else if (b == hrp_pkg::CH_SP || b == hrp_pkg::CH_TAB) state_next = s;
        else if (hrp_pkg::is_ctl(b)) st = hrp_pkg::ST_BAD;
        else begin
          state_next = hrp_pkg::S_VALUE;
          role       = hrp_pkg::ROLE_VALUE;
        end
      end
      hrp_pkg::S_NAME: begin
        if (b == hrp_pkg::CH_COLON) state_next = hrp_pkg::S_SPACE_VALUE;
        else if (hrp_pkg::is_token(b)) role = hrp_pkg::ROLE_NAME;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_SPACE_VALUE: begin
        if (b == hrp_pkg::CH_SP) state_next = hrp_pkg::S_VALUE;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VALUE: begin
        if (b == hrp_pkg::CH_CR) state_next = hrp_pkg::S_LF_HEADER;
        else if (hrp_pkg::is_ctl(b)) st = hrp_pkg::ST_BAD;
        else role = hrp_pkg::ROLE_VALUE;
      end
      hrp_pkg::S_LF_HEADER: begin
        if (b == hrp_pkg::CH_LF) state_next = hrp_pkg::S_LINE_START;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_LF_FINAL: begin
        st = (b == hrp_pkg::CH_LF) ? hrp_pkg::ST_DONE : hrp_pkg::ST_BAD;
      end
      default: begin
        st = hrp_pkg::ST_BAD;
      end
    endcase

    result_next.status        = st;
    result_next.byte_role     = role;
    result_next.echo_byte     = (role != hrp_pkg::ROLE_DELIM) ? b : 8'd0;
    result_next.version_major = major_value_next;
    result_next.version_minor = minor_value_next;
  end

  // Parser state registers advance with each byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hrp_pkg::S_METHOD_START;
      seen_header <= 1'b0;
      major_value <= 16'd0;
      minor_value <= 16'd0;
    end else if (advance) begin
      state       <= state_next;
      seen_header <= seen_header_next;
      major_value <= major_value_next;
      minor_value <= minor_value_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_item <= result_next;
    end
  end

endmodule

@@ design/hrp_checker.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser checker
// Port-level assertions on both channels, bound to the top level.
// ----------------------------------------------------------------------------
module hrp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input hrp_pkg::out_item_t out_item
);

  // A stalled result transaction stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result transaction changed");

  // Delimiter bytes are never echoed.
  a_delim_echo: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.byte_role == hrp_pkg::ROLE_DELIM |->
      out_item.echo_byte == 8'd0)
    else $error("delimiter byte echoed");

  // A malformed byte carries no role.
  a_bad_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == hrp_pkg::ST_BAD |->
      out_item.byte_role == hrp_pkg::ROLE_DELIM)
    else $error("malformed byte tagged with a role");

  // The input side only stalls behind a stalled result.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the result side free");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// HTTP request header parser testbench
// Feeds directed and randomly generated request bytes through the parser with
// random idle bursts on both channels. A software copy of the parse state
// machine predicts each result, and every result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  hrp_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  hrp_pkg::out_item_t out_item;

  // Bytes waiting to be sent and results waiting to be seen.
  hrp_pkg::in_item_t  request_bytes[$];
  hrp_pkg::out_item_t predicted_results[$];

  // Predicted parser state.
  hrp_pkg::parser_state_t ps = hrp_pkg::S_METHOD_START;
  bit                     hdr_seen = 1'b0;
  int                     major_acc = 0;
  int                     minor_acc = 0;

  logic in_took = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   errors = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_done = 0;
  int   n_bad = 0;
  int   n_requests = 0;

  http_request_header_parser uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Control characters are 0 to 31 and DEL.
  function automatic bit ctl_char(input logic [7:0] c);
    return (c < 8'd32) || (c == 8'd127);
  endfunction

  // Token characters are printable 7-bit characters outside the separator set.
  function automatic bit tok_char(input logic [7:0] c);
    if (c[7] || ctl_char(c)) return 1'b0;
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", " ": return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic bit dec_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // Decimal accumulation that sticks at the 16-bit maximum.
  function automatic int push_digit(input int v, input logic [7:0] c);
    int n;
    n = v * 10 + (c - "0");
    return (n > 65535) ? 65535 : n;
  endfunction

  // Advances the predicted parse state by one byte and returns its result.
  function automatic hrp_pkg::out_item_t parse_byte(input hrp_pkg::in_item_t it);
    hrp_pkg::out_item_t     r;
    logic [7:0]             b;
    logic [1:0]             st;
    logic [2:0]             role;
    hrp_pkg::parser_state_t nx;
    b = it.data_byte;
    st = hrp_pkg::ST_MORE;
    role = hrp_pkg::ROLE_DELIM;
    if (it.restart) begin
      ps = hrp_pkg::S_METHOD_START;
      hdr_seen = 1'b0;
      major_acc = 0;
      minor_acc = 0;
    end
    // A rejected byte leaves the state where it was.
    nx = ps;
    case (ps)
      hrp_pkg::S_METHOD_START: begin
        if (tok_char(b)) begin
          nx = hrp_pkg::S_METHOD;
          role = hrp_pkg::ROLE_METHOD;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_METHOD: begin
        if (b == hrp_pkg::CH_SP) nx = hrp_pkg::S_URI_START;
        else if (tok_char(b)) role = hrp_pkg::ROLE_METHOD;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_URI_START: begin
        if (ctl_char(b)) st = hrp_pkg::ST_BAD;
        else begin
          nx = hrp_pkg::S_URI;
          role = hrp_pkg::ROLE_URI;
        end
      end
      hrp_pkg::S_URI: begin
        if (b == hrp_pkg::CH_SP) nx = hrp_pkg::S_VER_H;
        else if (ctl_char(b)) st = hrp_pkg::ST_BAD;
        else role = hrp_pkg::ROLE_URI;
      end
      hrp_pkg::S_VER_H: begin
        if (b == hrp_pkg::CH_H) nx = hrp_pkg::S_VER_T1; else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_T1: begin
        if (b == hrp_pkg::CH_T) nx = hrp_pkg::S_VER_T2; else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_T2: begin
        if (b == hrp_pkg::CH_T) nx = hrp_pkg::S_VER_P; else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_P: begin
        if (b == hrp_pkg::CH_P) nx = hrp_pkg::S_VER_SLASH; else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_SLASH: begin
        if (b == hrp_pkg::CH_SLASH) begin
          major_acc = 0;
          minor_acc = 0;
          nx = hrp_pkg::S_MAJOR_START;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MAJOR_START: begin
        if (dec_char(b)) begin
          major_acc = push_digit(major_acc, b);
          nx = hrp_pkg::S_MAJOR;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MAJOR: begin
        if (b == hrp_pkg::CH_DOT) nx = hrp_pkg::S_MINOR_START;
        else if (dec_char(b)) major_acc = push_digit(major_acc, b);
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MINOR_START: begin
        if (dec_char(b)) begin
          minor_acc = push_digit(minor_acc, b);
          nx = hrp_pkg::S_MINOR;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MINOR: begin
        if (b == hrp_pkg::CH_CR) nx = hrp_pkg::S_LF_REQLINE;
        else if (dec_char(b)) minor_acc = push_digit(minor_acc, b);
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_LF_REQLINE: begin
        if (b == hrp_pkg::CH_LF) nx = hrp_pkg::S_LINE_START; else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_LINE_START: begin
        if (b == hrp_pkg::CH_CR) nx = hrp_pkg::S_LF_FINAL;
        else if (hdr_seen && (b == hrp_pkg::CH_SP || b == hrp_pkg::CH_TAB)) begin
          nx = hrp_pkg::S_LWS;
        end else if (tok_char(b)) begin
          hdr_seen = 1'b1;
          role = hrp_pkg::ROLE_NEW_NAME;
          nx = hrp_pkg::S_NAME;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_LWS: begin
        if (b == hrp_pkg::CH_CR) nx = hrp_pkg::S_LF_HEADER;
        else if (b == hrp_pkg::CH_SP || b == hrp_pkg::CH_TAB) nx = hrp_pkg::S_LWS;
        else if (ctl_char(b)) st = hrp_pkg::ST_BAD;
        else begin
          nx = hrp_pkg::S_VALUE;
          role = hrp_pkg::ROLE_VALUE;
        end
      end
      hrp_pkg::S_NAME: begin
        if (b == hrp_pkg::CH_COLON) nx = hrp_pkg::S_SPACE_VALUE;
        else if (tok_char(b)) role = hrp_pkg::ROLE_NAME;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_SPACE_VALUE: begin
        if (b == hrp_pkg::CH_SP) nx = hrp_pkg::S_VALUE; else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VALUE: begin
        if (b == hrp_pkg::CH_CR) nx = hrp_pkg::S_LF_HEADER;
        else if (ctl_char(b)) st = hrp_pkg::ST_BAD;
        else role = hrp_pkg::ROLE_VALUE;
      end
      hrp_pkg::S_LF_HEADER: begin
        if (b == hrp_pkg::CH_LF) nx = hrp_pkg::S_LINE_START; else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_LF_FINAL: begin
        st = (b == hrp_pkg::CH_LF) ? hrp_pkg::ST_DONE : hrp_pkg::ST_BAD;
      end
      default: st = hrp_pkg::ST_BAD;
    endcase
    ps = nx;
    r.status = st;
    r.byte_role = role;
    r.echo_byte = (role != hrp_pkg::ROLE_DELIM) ? b : 8'h00;
    r.version_major = major_acc[15:0];
    r.version_minor = minor_acc[15:0];
    return r;
  endfunction

  task automatic add_byte(input logic [7:0] b, input bit rs);
    request_bytes.insert(request_bytes.size(), '{data_byte: b, restart: rs});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_tok();
    logic [7:0] c;
    do c = 8'($urandom_range(126, 33)); while (!tok_char(c));
    return c;
  endfunction

  // Printable or high-half byte, never a space.
  function automatic logic [7:0] rand_txt();
    if ($urandom_range(3) == 0) return 8'($urandom_range(255, 128));
    return 8'($urandom_range(126, 33));
  endfunction

  function automatic logic [7:0] rand_dec();
    return hrp_pkg::CH_ZERO + 8'($urandom_range(9));
  endfunction

  // Builds one request, mostly well formed, sometimes damaged or pure noise.
  task automatic add_request();
    logic [7:0] line[$];
    logic [7:0] odd[5];
    string      ver_txt;
    int         n;
    int         pos;
    odd = '{hrp_pkg::CH_CR, hrp_pkg::CH_LF, hrp_pkg::CH_SP, hrp_pkg::CH_TAB,
            hrp_pkg::CH_COLON};
    ver_txt = " HTTP/";
    n_requests++;
    if ($urandom_range(14) == 0) begin
      n = $urandom_range(12, 1);
      repeat (n) add_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    // Request line.
    repeat ($urandom_range(6, 1)) line.insert(line.size(), rand_tok());
    line.insert(line.size(), hrp_pkg::CH_SP);
    line.insert(line.size(), ($urandom_range(9) == 0) ? hrp_pkg::CH_SP : rand_txt());
    repeat ($urandom_range(7)) line.insert(line.size(), rand_txt());
    for (int i = 0; i < ver_txt.len(); i++) line.insert(line.size(), ver_txt[i]);
    n = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(2, 1);
    repeat (n) line.insert(line.size(), rand_dec());
    line.insert(line.size(), hrp_pkg::CH_DOT);
    n = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(2, 1);
    repeat (n) line.insert(line.size(), rand_dec());
    line.insert(line.size(), hrp_pkg::CH_CR);
    line.insert(line.size(), hrp_pkg::CH_LF);
    // Header lines, some with folded continuation lines.
    repeat ($urandom_range(4)) begin
      repeat ($urandom_range(6, 1)) line.insert(line.size(), rand_tok());
      line.insert(line.size(), hrp_pkg::CH_COLON);
      line.insert(line.size(), hrp_pkg::CH_SP);
      repeat ($urandom_range(8)) begin
        line.insert(line.size(), ($urandom_range(7) == 0) ? hrp_pkg::CH_SP : rand_txt());
      end
      line.insert(line.size(), hrp_pkg::CH_CR);
      line.insert(line.size(), hrp_pkg::CH_LF);
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          line.insert(line.size(), $urandom_range(1) ? hrp_pkg::CH_SP : hrp_pkg::CH_TAB);
        end
        repeat ($urandom_range(5)) line.insert(line.size(), rand_txt());
        line.insert(line.size(), hrp_pkg::CH_CR);
        line.insert(line.size(), hrp_pkg::CH_LF);
      end
    end
    line.insert(line.size(), hrp_pkg::CH_CR);
    line.insert(line.size(), hrp_pkg::CH_LF);
    if ($urandom_range(5) == 0) begin
      line.insert(line.size(), $urandom_range(1) ? hrp_pkg::CH_LF : rand_txt());
    end
    // Occasional damage: overwrite, insert or cut short.
    pos = $urandom_range(line.size() - 1);
    case ($urandom_range(9))
      6: line[pos] = 8'($urandom_range(255));
      7: line.insert(pos, 8'($urandom_range(255)));
      8: while (line.size() > pos + 1) void'(line.pop_back());
      9: line[pos] = odd[$urandom_range(4)];
      default: ;
    endcase
    foreach (line[i]) add_byte(line[i], (i == 0) && ($urandom_range(9) != 0));
  endtask

  // Idle rate by stretch of the run; the tail runs without idling.
  function automatic int idle_pct();
    if (request_bytes.size() < 120) return 0;
    case ((request_bytes.size() / 150) % 3)
      0: return 0;
      1: return 8;
      default: return 30;
    endcase
  endfunction

  // Driver: a byte is held until taken, then the next one or a gap follows.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(99) < idle_pct()) begin
        gap_left = $urandom_range(11);
        in_valid <= 1'b0;
      end else begin
        in_item <= request_bytes.pop_front();
        in_valid <= 1'b1;
        n_sent++;
      end
    end
  end

  // Receiver back-pressure in bursts.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < idle_pct()) begin
      stall_left = $urandom_range(11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each accepted byte, check each accepted result.
  always @(posedge clk) begin : monitor
    hrp_pkg::out_item_t want;
    in_took <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      predicted_results.insert(predicted_results.size(), parse_byte(in_item));
    end
    if (!rst && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        if (errors < 10) $display("ERROR at %0t: result with nothing predicted", $realtime);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        n_checked++;
        if (out_item.status == hrp_pkg::ST_DONE) n_done++;
        if (out_item.status == hrp_pkg::ST_BAD) n_bad++;
        if (out_item.status !== want.status || out_item.byte_role !== want.byte_role ||
            out_item.echo_byte !== want.echo_byte ||
            out_item.version_major !== want.version_major ||
            out_item.version_minor !== want.version_minor) begin
          if (errors < 10) begin
            $display("ERROR at %0t: result %0d mismatch", $realtime, n_checked);
            $display("  want status=%0d role=%0d echo=%02h major=%0d minor=%0d",
                     want.status, want.byte_role, want.echo_byte,
                     want.version_major, want.version_minor);
            $display("  got  status=%0d role=%0d echo=%02h major=%0d minor=%0d",
                     out_item.status, out_item.byte_role, out_item.echo_byte,
                     out_item.version_major, out_item.version_minor);
          end
          errors++;
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Directed: URI starting with a high byte, saturating major version,
    // a fold before any header, completion, a repeated LF, then garbage.
    add_byte("M", 1'b1);
    add_byte(hrp_pkg::CH_SP, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_text(" HTTP/99999.7\r\n");
    add_text(" \r\n\n");
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    while (request_bytes.size() < 1050) add_request();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_bytes.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (predicted_results.size() != 0) errors += predicted_results.size();

    $display("Sent %0d bytes over %0d generated requests, checked %0d results.",
             n_sent, n_requests, n_checked);
    $display("Results seen: %0d request complete, %0d malformed byte.", n_done, n_bad);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(5_000_000);
    $display("Timeout with %0d results still outstanding.", predicted_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ http_request_header_parser.f @@
design/hrp_pkg.sv
design/http_request_header_parser.sv
design/hrp_checker.sv
tb/sv/tb_top.sv
